@@ rtl/core/urpw_pkg.sv @@
// ============================================================================
// urpw_pkg: shared types and constants of the user range page-walk checker
// Table geometry, entry bit positions, codes and the control structs.
// ============================================================================
`timescale 1ns / 1ps

package urpw_pkg;

   // table store geometry
   localparam int TABLE_WORDS_LOG2 = 16;
   localparam int SLOT_W           = 9;
   localparam int TBL_IDX_W        = TABLE_WORDS_LOG2;
   localparam int BASE_IDX_W       = TABLE_WORDS_LOG2 - SLOT_W;

   // address and entry layout
   localparam int PAGE_SHIFT   = 12;
   localparam int PHYS_W       = 52;
   localparam int USER_VA_W    = 47;
   localparam int PAGE_NUM_W   = 64 - PAGE_SHIFT;
   localparam int FRAME_W      = PHYS_W - PAGE_SHIFT;
   localparam int USER_TOP_PG  = USER_VA_W - PAGE_SHIFT;
   localparam int BIT_PRESENT  = 0;
   localparam int BIT_WRITE    = 1;
   localparam int BIT_USER     = 2;

   localparam logic [USER_VA_W-1:0] USER_BASE_RESET = USER_VA_W'(4096);

   // item and register codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;
   localparam logic CSR_ROOT   = 1'b0;
   localparam logic CSR_UBASE  = 1'b1;

   typedef enum logic [1:0] {
      LVL_PML4 = 2'd0,
      LVL_PDPT = 2'd1,
      LVL_PD   = 2'd2,
      LVL_PT   = 2'd3
   } level_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_PAGE,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [PHYS_W-1:0]    root;
      logic [USER_VA_W-1:0] ubase;
   } cfg_type;

   typedef struct packed {
      logic        func;
      logic [15:0] word_index;
      logic [63:0] word_data;
      logic [63:0] range_va;
      logic [31:0] byte_length;
      logic        need_write;
   } req_payload_type;

   typedef struct packed {
      logic accept;
      logic is_check;
   } beat_type;

   typedef struct packed {
      logic take;
      logic write_word;
      logic load_item;
      logic init_pages;
      logic start_walk;
      logic read;
      logic descend;
      logic next_page;
      logic fail;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic zero_len;
      logic wrap;
      logic window_ok;
      logic outside;
      logic entry_ok;
      logic leaf;
      logic write_ok;
      logic end_page;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/core/urpw_req_if.sv @@
// ============================================================================
// urpw_req_if: request channel of the page-walk checker
// Valid/ready channel that carries one write or check item per beat.
// ============================================================================
`timescale 1ns / 1ps

interface urpw_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] word_index;
   logic [63:0] word_data;
   logic [63:0] range_va;
   logic [31:0] byte_length;
   logic        need_write;

   modport source (
      output valid, func, word_index, word_data, range_va, byte_length,
             need_write,
      input  ready
   );

   modport sink (
      input  valid, func, word_index, word_data, range_va, byte_length,
             need_write,
      output ready
   );
endinterface

@@ rtl/core/urpw_rsp_if.sv @@
// ============================================================================
// urpw_rsp_if: response channel of the page-walk checker
// Valid/ready channel that carries one verdict per beat.
// ============================================================================
`timescale 1ns / 1ps

interface urpw_rsp_if;
   logic valid;
   logic ready;
   logic accessible;

   modport source (
      output valid, accessible,
      input  ready
   );

   modport sink (
      input  valid, accessible,
      output ready
   );
endinterface

@@ rtl/core/user_range_page_walk_check.sv @@
// ============================================================================
// user_range_page_walk_check: user range page-walk checker
// Write beat: stored as it is taken, no response. Check beat: a setup step, then
// per 4 KiB page a window check plus four read/evaluate steps through the single
// table read port, then a step into the response register; a failing page
// ends the walk early. One check in flight at a time.
// Reset: synchronous; the table store is then swept to zero, word by word, while
// no request beat is taken (register writes are taken throughout).
// ============================================================================
`timescale 1ns / 1ps

module user_range_page_walk_check
   import urpw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   urpw_req_if.sink    req_chan,
   urpw_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [PHYS_W-1:0]    root_ff;
   logic [USER_VA_W-1:0] ubase_ff;
   logic                 csr_wr;
   logic                 csr_sel;

   cfg_type         cfg;
   req_payload_type req;
   beat_type        beat;
   cmd_type         cmd;
   stat_type        stat;

   // ------------------------------------------------------------------------
   // Register port: 64-bit registers at byte addresses 0 and 8, so bit 3 of
   // the address picks the register. Writes complete in the access phase.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= '0;
         ubase_ff <= USER_BASE_RESET;
      end else if (csr_wr) begin
         // keep only the implemented bits of each register
         case (csr_sel)
            CSR_ROOT:  root_ff  <= csr_pwdata[PHYS_W-1:0];
            CSR_UBASE: ubase_ff <= csr_pwdata[USER_VA_W-1:0];
            default:   root_ff  <= root_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_ROOT:  csr_prdata = 64'(root_ff);
         CSR_UBASE: csr_prdata = 64'(ubase_ff);
         default:   csr_prdata = '0;
      endcase
   end

   assign cfg.root  = root_ff;
   assign cfg.ubase = ubase_ff;

   // ------------------------------------------------------------------------
   // Request beat: the sequencer takes beats only while idle; a write beat is
   // stored in the same cycle, a check beat starts a walk.
   // ------------------------------------------------------------------------
   assign req_chan.ready = cmd.take;
   assign beat.accept    = req_chan.valid && cmd.take;
   assign beat.is_check  = req_chan.func == FUNC_CHECK;

   assign req.func        = req_chan.func;
   assign req.word_index  = req_chan.word_index;
   assign req.word_data   = req_chan.word_data;
   assign req.range_va    = req_chan.range_va;
   assign req.byte_length = req_chan.byte_length;
   assign req.need_write  = req_chan.need_write;

   urpw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .beat  (beat),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Response beat comes straight from the datapath's output register, so a
   // new request can be taken while the previous verdict still waits.
   urpw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req            (req),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_chan.valid),
      .rsp_accessible (rsp_chan.accessible),
      .rsp_ready      (rsp_chan.ready)
   );

endmodule

@@ rtl/core/urpw_ctrl.sv @@
// ============================================================================
// urpw_ctrl: walk sequencer
// Steps through range setup, per-page window check and four table levels.
// ============================================================================
`timescale 1ns / 1ps

module urpw_ctrl
   import urpw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  beat_type beat,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (!stat.clearing) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (beat.accept && beat.is_check) state_in = S_PREP;
         end
         S_PREP: begin
            if (stat.zero_len || stat.wrap) state_in = S_DONE;
            else                           state_in = S_PAGE;
         end
         S_PAGE: begin
            if (stat.window_ok) state_in = S_READ;
            else                state_in = S_DONE;
         end
         S_READ: begin
            if (stat.outside) state_in = S_DONE;
            else              state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!stat.entry_ok)                   state_in = S_DONE;
            else if (!stat.leaf)                  state_in = S_READ;
            else if (!stat.write_ok)              state_in = S_DONE;
            else if (stat.end_page)               state_in = S_DONE;
            else                                  state_in = S_PAGE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_CLEAR: begin
         end
         S_IDLE: begin
            cmd.take       = 1'b1;
            cmd.write_word = beat.accept && !beat.is_check;
            cmd.load_item  = beat.accept && beat.is_check;
         end
         S_PREP: begin
            cmd.fail       = !stat.zero_len && stat.wrap;
            cmd.init_pages = !stat.zero_len && !stat.wrap;
         end
         S_PAGE: begin
            cmd.fail       = !stat.window_ok;
            cmd.start_walk = stat.window_ok;
         end
         S_READ: begin
            cmd.fail = stat.outside;
            cmd.read = !stat.outside;
         end
         S_EVAL: begin
            cmd.fail      = !stat.entry_ok || (stat.leaf && !stat.write_ok);
            cmd.descend   = stat.entry_ok && !stat.leaf;
            cmd.next_page = stat.entry_ok && stat.leaf && stat.write_ok &&
                            !stat.end_page;
         end
         S_DONE: begin
            cmd.push = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/urpw_datapath.sv @@
// ============================================================================
// urpw_datapath: table store, range registers and entry checks
// Holds the table memory, its reset sweep, the walk registers and the
// response register.
// ============================================================================
`timescale 1ns / 1ps

module urpw_datapath
   import urpw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  req_payload_type req,
   input  cmd_type         cmd,
   output stat_type        stat,
   output logic            rsp_valid,
   output logic            rsp_accessible,
   input  logic            rsp_ready
);

   logic [63:0] mem [2**TBL_IDX_W];

   logic                  clr_active_ff;
   logic [TBL_IDX_W-1:0]  clr_idx_ff;
   logic [63:0]           va_ff;
   logic [31:0]           len_ff;
   logic                  need_write_ff;
   logic [PAGE_NUM_W-1:0] page_ff;
   logic [PAGE_NUM_W-1:0] end_page_ff;
   logic [FRAME_W-1:0]    base_ff;
   level_type             level_ff;
   logic [63:0]           rd_data_ff;
   logic                  verdict_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_acc_ff;

   logic [64:0]           range_sum;
   logic [SLOT_W-1:0]     slot;
   logic [TBL_IDX_W-1:0]  rd_idx;
   logic [TBL_IDX_W-1:0]  wr_idx;
   logic                  wr_in_range;

   // last byte of the range, carry out flags a wrap
   assign range_sum = {1'b0, va_ff} + 65'(len_ff - 32'd1);

   always_comb begin
      case (level_ff)
         LVL_PML4: slot = page_ff[35:27];
         LVL_PDPT: slot = page_ff[26:18];
         LVL_PD:   slot = page_ff[17:9];
         LVL_PT:   slot = page_ff[8:0];
         default:  slot = page_ff[8:0];
      endcase
   end

   assign rd_idx      = {base_ff[BASE_IDX_W-1:0], slot};
   assign wr_idx      = TBL_IDX_W'(req.word_index);
   assign wr_in_range = (32'(req.word_index) >> TABLE_WORDS_LOG2) == 32'd0;

   always_comb begin
      stat.clearing  = clr_active_ff;
      stat.zero_len  = len_ff == 32'd0;
      stat.wrap      = range_sum[64];
      stat.window_ok = ((page_ff >> USER_TOP_PG) == '0) &&
                       ({page_ff[USER_TOP_PG-1:0], PAGE_SHIFT'(0)} >= cfg.ubase);
      stat.outside   = (base_ff >> BASE_IDX_W) != '0;
      stat.entry_ok  = rd_data_ff[BIT_PRESENT] && rd_data_ff[BIT_USER];
      stat.leaf      = level_ff == LVL_PT;
      stat.write_ok  = rd_data_ff[BIT_WRITE] || !need_write_ff;
      stat.end_page  = page_ff == end_page_ff;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // table memory: sweep to zero after reset, then item writes
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (cmd.write_word && wr_in_range) begin
         mem[wr_idx] <= req.word_data;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == '1) clr_active_ff <= 1'b0;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         va_ff         <= req.range_va;
         len_ff        <= req.byte_length;
         need_write_ff <= req.need_write;
      end
      if (cmd.init_pages) begin
         page_ff     <= va_ff[63:PAGE_SHIFT];
         end_page_ff <= range_sum[63:PAGE_SHIFT];
      end else if (cmd.next_page) begin
         page_ff <= page_ff + 1'b1;
      end
      if (cmd.start_walk) begin
         base_ff  <= cfg.root[PHYS_W-1:PAGE_SHIFT];
         level_ff <= LVL_PML4;
      end else if (cmd.descend) begin
         base_ff  <= rd_data_ff[PHYS_W-1:PAGE_SHIFT];
         level_ff <= level_type'(level_ff + 2'd1);
      end
   end

   // verdict and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_item)  verdict_ff <= 1'b1;
         else if (cmd.fail)  verdict_ff <= 1'b0;
         if (cmd.push)                     rsp_valid_ff <= 1'b1;
         else if (rsp_ready)               rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) rsp_acc_ff <= verdict_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accessible = rsp_acc_ff;

   a_read_in_store: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> !stat.outside)
      else $error("table read issued outside the store");

   a_descend_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.descend |-> $past(cmd.read))
      else $error("entry used without a read in the previous cycle");

   a_no_item_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !(cmd.load_item || cmd.write_word))
      else $error("item taken during the clearing sweep");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.push)
      else $error("pending response overwritten");

endmodule
